@@ hw/rtl/lfg_pkg.sv @@
// lfg_pkg: widths, register indexes, class codes and helpers for the forget gate
// used by the top level, the sigmoid rom and the port checker

package lfg_pkg;

    localparam int DATA_W    = 16;
    localparam int REG_W     = 48;
    localparam int MAX_CELLS = 3;
    localparam int IDX_W     = 3;
    localparam int SUM_W     = 35;
    localparam int PROD_W    = 32;
    localparam int FRAC_W    = 12;
    localparam int Z_FULL_W  = 28;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 56;
    localparam int CLS_W     = 2;

    localparam logic [DATA_W-1:0] KEEP_ABOVE = 16'd52428;
    localparam logic [DATA_W-1:0] ERASE_MAX  = 16'd19660;

    typedef enum logic [IDX_W-1:0] {
        REG_INPUT_W = 3'd0,
        REG_REC_0   = 3'd1,
        REG_REC_1   = 3'd2,
        REG_REC_2   = 3'd3,
        REG_BIAS    = 3'd4
    } t_reg_idx;

    typedef enum logic [CLS_W-1:0] {
        CLS_ERASE   = 2'd0,
        CLS_PARTIAL = 2'd1,
        CLS_KEEP    = 2'd2
    } t_class;

    function automatic logic signed [DATA_W-1:0] field16(input logic [REG_W-1:0] w,
                                                          input int pos);
        return w[pos*DATA_W +: DATA_W];
    endfunction

endpackage

@@ hw/rtl/lfg_sigmoid_rom.sv @@
// lfg_sigmoid_rom: sigmoid table with a registered read port, built at elaboration
// depends on lfg_pkg for the gate width

module lfg_sigmoid_rom import lfg_pkg::*; #(
    parameter int TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS-1:0] i_addr,
    output logic [DATA_W-1:0]     o_data
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int HALF_TABLE = 1 << (TABLE_BITS - 1);

    typedef logic [DATA_W-1:0] t_rom [TABLE_SIZE];

    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [DATA_W-1:0] round_div(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] q;
        q = udiv64((num << 1) + den, den << 1);
        return q[DATA_W-1:0];
    endfunction

    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] term;
        logic [63:0] base;
        logic [63:0] e;
        logic [63:0] e40;
        logic [63:0] den;
        term = 64'd1 << 62;
        base = 64'd1 << 62;
        e    = 64'd1 << 62;
        for (int k = 1; k < 64; k++) begin
            if (term != 64'd0) begin
                term = udiv64(term, 64'(256 * k));
                if (k % 2 == 1) base = base - term;
                else base = base + term;
            end
        end
        for (int i = TABLE_BITS; i < 12; i++) base = mul_q62(base, base);
        for (int j = 0; j <= HALF_TABLE; j++) begin
            e40 = (e + (64'd1 << 21)) >> 22;
            den = (64'd1 << 40) + e40;
            if (j < HALF_TABLE) rom[HALF_TABLE + j] = round_div(64'd65535 << 40, den);
            rom[HALF_TABLE - j] = round_div(64'd65535 * e40, den);
            e = mul_q62(e, base);
        end
        return rom;
    endfunction

    localparam t_rom SIG_ROM = build_rom();

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) r_data <= SIG_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/lstm_forget_gate.sv @@
// lstm_forget_gate: three-cell lstm forget gate, five-stage pipeline
// depends on lfg_pkg and lfg_sigmoid_rom
//
// channel   dir  beat fields (low bit up)
// s_axis    in   x_sample, hidden_0, hidden_1, hidden_2 (16 bits each)
// m_axis    out  gate_0, gate_1, gate_2 (16 each), class_0..class_2 (2 each), pad
// cfg       in   write enable, register index, 48-bit data
//
// one beat per cycle in, one beat per cycle out, unless the output stalls on m_axis_tready
// stages: products, sum, saturate and round, rom read, classify
// reset clears stage valids and the weight registers
// the whole pipeline holds while the output beat waits on m_axis_tready

module lstm_forget_gate import lfg_pkg::*; #(
    parameter int CELLS              = 3,
    parameter int SIGMOID_TABLE_BITS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [REG_W-1:0]    i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // x_sample, hidden_0, hidden_1, hidden_2
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata    // gate_0..2, class_0..2, zero pad
);

    localparam int TB  = SIGMOID_TABLE_BITS;
    localparam int SH  = Z_FULL_W - TB;
    localparam logic signed [SUM_W-1:0] Z_LO = -(SUM_W'(1) <<< (Z_FULL_W - 1));
    localparam logic signed [SUM_W-1:0] Z_HI = (SUM_W'(1) <<< (Z_FULL_W - 1)) - 1;

    logic [REG_W-1:0] r_reg [5];
    logic             en;
    logic             r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [PROD_W-1:0] r_px [MAX_CELLS];
    logic signed [PROD_W-1:0] r_ph [MAX_CELLS][MAX_CELLS];
    logic signed [DATA_W-1:0] r_b1 [MAX_CELLS];
    logic signed [SUM_W-1:0]  r_z  [MAX_CELLS];
    logic [TB-1:0]            r_idx [MAX_CELLS];
    logic [TB-1:0]            n_idx [MAX_CELLS];
    logic [DATA_W-1:0]        rom_q [MAX_CELLS];
    logic [DATA_W-1:0]        r_gate [MAX_CELLS];
    t_class                   r_cls [MAX_CELLS];

    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] h_in [MAX_CELLS];

    assign en            = !r_v5 || m_axis_tready;
    assign s_axis_tready = en;
    assign x_in          = s_axis_tdata[DATA_W-1:0];
    always_comb begin
        for (int j = 0; j < MAX_CELLS; j++) h_in[j] = s_axis_tdata[(j+1)*DATA_W +: DATA_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 5; r++) r_reg[r] <= '0;
        end else if (i_cfg_we && i_cfg_idx <= REG_BIAS) begin
            r_reg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < MAX_CELLS; c++) begin
                r_b1[c] <= field16(r_reg[REG_BIAS], c);
                r_px[c] <= field16(r_reg[REG_INPUT_W], c) * x_in;
                for (int j = 0; j < MAX_CELLS; j++) begin
                    if (j < CELLS) r_ph[c][j] <= field16(r_reg[REG_REC_0 + c], j) * h_in[j];
                    else r_ph[c][j] <= '0;
                end
            end
        end
    end

    // stage 2: sum
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < MAX_CELLS; c++) begin
                r_z[c] <= (SUM_W'(r_b1[c]) <<< FRAC_W) + SUM_W'(r_px[c])
                        + SUM_W'(r_ph[c][0]) + SUM_W'(r_ph[c][1]) + SUM_W'(r_ph[c][2]);
            end
        end
    end

    // stage 3: saturate and round to a table index
    always_comb begin
        logic [Z_FULL_W-1:0] u;
        logic signed [SUM_W-1:0] zs;
        logic [Z_FULL_W:0]   rs;
        logic [TB:0]         iw;
        for (int c = 0; c < MAX_CELLS; c++) begin
            priority if (r_z[c] < Z_LO) zs = Z_LO;
            else if (r_z[c] > Z_HI) zs = Z_HI;
            else zs = r_z[c];
            u  = Z_FULL_W'(zs - Z_LO);
            rs = {1'b0, u} + ((Z_FULL_W+1)'(1) << (SH - 1));
            iw = (TB+1)'(rs >> SH);
            n_idx[c] = iw[TB] ? {TB{1'b1}} : iw[TB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < MAX_CELLS; c++) r_idx[c] <= n_idx[c];
        end
    end

    // stage 4: table read
    for (genvar c = 0; c < MAX_CELLS; c++) begin : g_rom
        lfg_sigmoid_rom #(
            .TABLE_BITS(TB)
        ) u_rom (
            .i_clk (i_clk),
            .i_en  (en),
            .i_addr(r_idx[c]),
            .o_data(rom_q[c])
        );
    end

    // stage 5: classify
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < MAX_CELLS; c++) begin
                if (c >= CELLS) begin
                    r_gate[c] <= '0;
                    r_cls[c]  <= CLS_ERASE;
                end else begin
                    r_gate[c] <= rom_q[c];
                    priority if (rom_q[c] > KEEP_ABOVE) r_cls[c] <= CLS_KEEP;
                    else if (rom_q[c] <= ERASE_MAX) r_cls[c] <= CLS_ERASE;
                    else r_cls[c] <= CLS_PARTIAL;
                end
            end
        end
    end

    assign m_axis_tvalid = r_v5;
    assign m_axis_tdata  = {2'b00, r_cls[2], r_cls[1], r_cls[0],
                            r_gate[2], r_gate[1], r_gate[0]};

endmodule

@@ hw/rtl/lfg_checker.sv @@
// lfg_checker: port-level assertions for lstm_forget_gate, bound to the top level
// depends on lfg_pkg for class codes and thresholds

module lfg_checker import lfg_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [M_DATA_W-1:0] m_axis_tdata
);

    // no output beat right after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // output beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    // input side opens whenever the output side can move
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output side");

    // keep class on cell 0 only above the keep threshold
    a_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[49:48] == CLS_KEEP |-> m_axis_tdata[15:0] > KEEP_ABOVE)
        else $error("keep class with low gate");

    // class code three never appears
    a_cls_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[49:48] != 2'd3 && m_axis_tdata[51:50] != 2'd3
                          && m_axis_tdata[53:52] != 2'd3)
        else $error("bad class code");

endmodule

bind lstm_forget_gate lfg_checker u_lfg_checker (.*);
